### rtl/http_header_block_parser_assert.svh
// Assertion macros used by the checker file.
`ifndef HTTP_HEADER_BLOCK_PARSER_ASSERT_SVH
`define HTTP_HEADER_BLOCK_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HHBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhbp assertion failed");

// Next-cycle implication.
`define HHBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhbp assertion failed");

`endif

### rtl/hhbp_pkg.sv
`timescale 1ns / 1ps

package hhbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 10;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CauseW  = 3;

  localparam logic [OffsetW-1:0] MaxOffsetReset = 10'd255;

  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChColon = 8'd58;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_KEY     = 4'd1,
    ST_COLON   = 4'd2,
    ST_SPACE   = 4'd3,
    ST_VALUE   = 4'd4,
    ST_CR      = 4'd5,
    ST_LF      = 4'd6,
    ST_END_CR  = 4'd7,
    ST_BODY    = 4'd8,
    ST_ERROR   = 4'd9
  } state_t;

  typedef enum logic [KindW-1:0] {
    K_SKIP      = 3'd0,
    K_KEY       = 3'd1,
    K_VALUE     = 3'd2,
    K_FIELD_END = 3'd3,
    K_BLOCK_END = 3'd4,
    K_ERROR     = 3'd5,
    K_BODY      = 3'd6
  } kind_t;

  typedef enum logic [CauseW-1:0] {
    C_NONE      = 3'd0,
    C_CRLF_KEY  = 3'd1,
    C_NO_SPACE  = 3'd2,
    C_VAL_LONG  = 3'd3,
    C_CR_NO_LF  = 3'd4,
    C_BAD_END   = 3'd5
  } cause_t;

  typedef struct packed {
    kind_t  kind;
    cause_t cause;
  } tag_t;

endpackage

### rtl/hhbp_parser.sv
`timescale 1ns / 1ps

// Per-byte header state machine. State advances on step; tag is combinational
// from the current byte and state.
module hhbp_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [hhbp_pkg::ByteW-1:0]   data_byte,
  input  logic                         new_request,
  input  logic [hhbp_pkg::OffsetW-1:0] max_value_offset,
  output hhbp_pkg::tag_t               tag
);
  import hhbp_pkg::*;

  state_t               state_r, state_nxt, cur_state;
  logic [OffsetW-1:0]   offset_r, offset_nxt, cur_offset;
  cause_t               hold_r, hold_nxt, cur_hold;
  logic [OffsetW:0]     offset_inc;
  logic                 is_crlf;
  logic                 too_long;

  // new_request restarts the parser before this byte is handled
  always_comb begin
    cur_state  = new_request ? ST_START : state_r;
    cur_offset = new_request ? '0 : offset_r;
    cur_hold   = new_request ? C_NONE : hold_r;
  end

  assign is_crlf    = (data_byte == ChCr) || (data_byte == ChLf);
  assign offset_inc = {1'b0, cur_offset} + {{OffsetW{1'b0}}, 1'b1};
  assign too_long   = offset_inc > {1'b0, max_value_offset};

  // next state
  always_comb begin
    state_nxt  = cur_state;
    offset_nxt = cur_offset;
    hold_nxt   = cur_hold;
    unique case (cur_state)
      ST_START: begin
        if (!is_crlf) state_nxt = ST_KEY;
      end
      ST_KEY: begin
        if (data_byte == ChColon) begin
          state_nxt = ST_COLON;
        end else if (is_crlf) begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_CRLF_KEY;
        end
      end
      ST_COLON: begin
        if (data_byte == ChSpace) begin
          state_nxt = ST_SPACE;
        end else begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_NO_SPACE;
        end
      end
      ST_SPACE: begin
        state_nxt  = ST_VALUE;
        offset_nxt = '0;
      end
      ST_VALUE: begin
        if (data_byte == ChCr) begin
          state_nxt = ST_CR;
        end else if (too_long) begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_VAL_LONG;
        end else begin
          offset_nxt = offset_inc[OffsetW-1:0];
        end
      end
      ST_CR: begin
        if (data_byte == ChLf) begin
          state_nxt = ST_LF;
        end else begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_CR_NO_LF;
        end
      end
      ST_LF: begin
        if (data_byte == ChCr) begin
          state_nxt = ST_END_CR;
        end else if (data_byte == ChLf) begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_CRLF_KEY;
        end else begin
          state_nxt = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (data_byte == ChLf) begin
          state_nxt = ST_BODY;
        end else begin
          state_nxt = ST_ERROR;
          hold_nxt  = C_BAD_END;
        end
      end
      ST_BODY: state_nxt = ST_BODY;
      default: state_nxt = ST_ERROR;
    endcase
  end

  // outputs
  always_comb begin
    tag.kind  = K_SKIP;
    tag.cause = C_NONE;
    unique case (cur_state)
      ST_START: begin
        if (!is_crlf) tag.kind = K_KEY;
      end
      ST_KEY: begin
        if (data_byte != ChColon) begin
          tag.kind = is_crlf ? K_ERROR : K_KEY;
        end
      end
      ST_COLON: begin
        if (data_byte != ChSpace) tag.kind = K_ERROR;
      end
      ST_SPACE: tag.kind = K_VALUE;
      ST_VALUE: begin
        if (data_byte != ChCr) tag.kind = too_long ? K_ERROR : K_VALUE;
      end
      ST_CR:     tag.kind = (data_byte == ChLf) ? K_FIELD_END : K_ERROR;
      ST_LF: begin
        if (data_byte == ChLf) tag.kind = K_ERROR;
        else if (data_byte != ChCr) tag.kind = K_KEY;
      end
      ST_END_CR: tag.kind = (data_byte == ChLf) ? K_BLOCK_END : K_ERROR;
      ST_BODY:   tag.kind = K_BODY;
      default:   tag.kind = K_ERROR;
    endcase
    if (tag.kind == K_ERROR) tag.cause = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      offset_r <= '0;
      hold_r   <= C_NONE;
    end else if (step) begin
      state_r  <= state_nxt;
      offset_r <= offset_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

### rtl/http_header_block_parser.sv
// An accepted item moves from the input register to the result register;
// out_valid rises once the item is in the result register.
// Throughput: one byte per cycle while out_stall is low; the parser state
// updates as an item moves from the input register to the result register.
// Reset (synchronous, rst_n low): pipeline empty, parser at start of header
// block, value offset and held cause zero, max_value_offset back to 255.
`timescale 1ns / 1ps

module http_header_block_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hhbp_pkg::ByteW-1:0]   in_data_byte,
  input  logic                         in_new_request,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hhbp_pkg::ByteW-1:0]   out_byte_out,
  output logic [hhbp_pkg::KindW-1:0]   out_kind,
  output logic [hhbp_pkg::CauseW-1:0]  out_err_cause,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hhbp_pkg::OffsetW-1:0] cfg_data
);
  import hhbp_pkg::*;

  logic               a_vld_r;
  logic [ByteW-1:0]   a_byte_r;
  logic               a_newreq_r;
  logic               b_vld_r;
  logic [ByteW-1:0]   b_byte_r;
  tag_t               b_tag_r;
  logic [OffsetW-1:0] max_off_r;
  logic               b_free;
  logic               step;
  logic               in_take;
  tag_t               tag;

  assign b_free   = !b_vld_r || !out_stall;
  assign step     = a_vld_r && b_free;
  assign in_stall = a_vld_r && !b_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_off_r <= MaxOffsetReset;
    end else if (cfg_valid) begin
      max_off_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_take) begin
      a_vld_r <= 1'b1;
    end else if (step) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r   <= in_data_byte;
      a_newreq_r <= in_new_request;
    end
  end

  hhbp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .data_byte        (a_byte_r),
    .new_request      (a_newreq_r),
    .max_value_offset (max_off_r),
    .tag              (tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b_byte_r <= a_byte_r;
      b_tag_r  <= tag;
    end
  end

  assign out_valid     = b_vld_r;
  assign out_byte_out  = b_byte_r;
  assign out_kind      = b_tag_r.kind;
  assign out_err_cause = b_tag_r.cause;

endmodule

### rtl/hhbp_checker.sv
`timescale 1ns / 1ps
`include "http_header_block_parser_assert.svh"

module hhbp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [hhbp_pkg::ByteW-1:0]   in_data_byte,
  input logic                         in_new_request,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [hhbp_pkg::ByteW-1:0]   out_byte_out,
  input logic [hhbp_pkg::KindW-1:0]   out_kind,
  input logic [hhbp_pkg::CauseW-1:0]  out_err_cause,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [hhbp_pkg::OffsetW-1:0] cfg_data
);
  import hhbp_pkg::*;

  // a cause shows only on error items
  `HHBP_ASSERT_IMP(a_cause_only_on_error, out_valid && (out_kind != K_ERROR), out_err_cause == C_NONE)

  // key bytes are never line terminators
  `HHBP_ASSERT_IMP(a_key_not_crlf, out_valid && (out_kind == K_KEY), (out_byte_out != ChCr) && (out_byte_out != ChLf))

  // field and block ends are tagged on the LF byte
  `HHBP_ASSERT_IMP(a_end_on_lf, out_valid && ((out_kind == K_FIELD_END) || (out_kind == K_BLOCK_END)), out_byte_out == ChLf)

  // a stalled result holds
  `HHBP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte_out) && $stable(out_kind) && $stable(out_err_cause))

endmodule

bind http_header_block_parser hhbp_checker u_hhbp_checker (.*);
